>>> rtl/prb_pkg.sv
// Shared types and constants for the palette remap blitter.
`timescale 1ns / 1ps

package prb_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int INDEX_W       = 8;
    localparam int COLOR_W       = 16;
    localparam int DEST_ADDR_W   = 24;
    localparam int CFG_W         = 16;
    localparam int CFG_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [0:0] {
        OP_TABLE_WRITE = 1'b0,
        OP_BITMAP_BYTE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_ROW_STRIDE = 2'd0,
        REG_START_X    = 2'd1,
        REG_START_Y    = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic               operation;
        logic [INDEX_W-1:0] table_index;
        logic [COLOR_W-1:0] table_value;
        logic [INDEX_W-1:0] data_byte;
    } in_req_t;

    typedef struct packed {
        logic [DEST_ADDR_W-1:0] dest_address;
        logic [COLOR_W-1:0]     pixel_value;
        logic                   last_pixel;
    } out_req_t;

    // Command passed from the parser to the table/output side.
    typedef struct packed {
        logic                   is_write;
        logic [INDEX_W-1:0]     index;
        logic [COLOR_W-1:0]     value;
        logic [DEST_ADDR_W-1:0] dest_address;
        logic                   last_pixel;
    } cmd_t;

endpackage

>>> rtl/prb_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module prb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/prb_front.sv
// Front end: accepts requests, parses the bitmap header and computes pixel addresses.
`timescale 1ns / 1ps

module prb_front
    import prb_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CFG_W-1:0] row_stride,
    input  logic [CFG_W-1:0] start_x,
    input  logic [CFG_W-1:0] start_y,
    input  logic             hold,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_req_t          s_payload,
    output logic             q_push,
    output cmd_t             q_cmd,
    input  logic             q_ready
);

    typedef enum logic [4:0] {
        PH_WIDTH_LO  = 5'b00001,
        PH_WIDTH_HI  = 5'b00010,
        PH_HEIGHT_LO = 5'b00100,
        PH_HEIGHT_HI = 5'b01000,
        PH_PIXELS    = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [CFG_W-1:0]       width_reg, width_next;
    logic [CFG_W-1:0]       height_reg, height_next;
    logic [CFG_W-1:0]       col_reg, col_next;
    logic [CFG_W-1:0]       row_reg, row_next;
    logic [ADDR_BITS-1:0]   row_base_reg, row_base_next;
    logic [2*CFG_W-1:0]     base_prod_reg;

    logic                   accept;
    logic                   is_write;
    logic                   in_pixels;
    logic [CFG_W:0]         col_inc_full;
    logic [CFG_W:0]         row_inc_full;
    logic [CFG_W-1:0]       col_inc;
    logic                   last;
    logic                   row_end;
    logic [ADDR_BITS-1:0]   pixel_addr;
    logic [ADDR_BITS-1:0]   header_base;
    logic [CFG_W-1:0]       hdr_height;

    // start_y * row_stride, refreshed every cycle; the top holds off input after a write
    always_ff @(posedge aclk) begin
        base_prod_reg <= (2*CFG_W)'(start_y) * (2*CFG_W)'(row_stride);
    end

    assign s_ready   = q_ready && !hold;
    assign accept    = s_valid && s_ready;
    assign is_write  = (s_payload.operation == OP_TABLE_WRITE);
    assign in_pixels = (phase_reg == PH_PIXELS);
    assign q_push    = accept && (is_write || in_pixels);

    assign col_inc_full = {1'b0, col_reg} + (CFG_W+1)'(1);
    assign row_inc_full = {1'b0, row_reg} + (CFG_W+1)'(1);
    assign col_inc      = col_inc_full[CFG_W-1:0];
    assign last         = (col_inc_full == {1'b0, width_reg}) &&
                          (row_inc_full == {1'b0, height_reg});
    assign row_end      = (col_inc >= width_reg);
    assign pixel_addr   = row_base_reg + ADDR_BITS'(col_reg);
    assign header_base  = ADDR_BITS'(base_prod_reg + (2*CFG_W)'(start_x));
    assign hdr_height   = {s_payload.data_byte, height_reg[INDEX_W-1:0]};

    always_comb begin
        q_cmd.is_write     = is_write;
        q_cmd.index        = is_write ? s_payload.table_index : s_payload.data_byte;
        q_cmd.value        = s_payload.table_value;
        q_cmd.dest_address = DEST_ADDR_W'(pixel_addr);
        q_cmd.last_pixel   = last;
    end

    always_comb begin
        phase_next    = phase_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (accept && !is_write) begin
            unique case (phase_reg)
                PH_WIDTH_LO: begin
                    width_next = {{(CFG_W-INDEX_W){1'b0}}, s_payload.data_byte};
                    phase_next = PH_WIDTH_HI;
                end
                PH_WIDTH_HI: begin
                    width_next = {s_payload.data_byte, width_reg[INDEX_W-1:0]};
                    phase_next = PH_HEIGHT_LO;
                end
                PH_HEIGHT_LO: begin
                    height_next = {{(CFG_W-INDEX_W){1'b0}}, s_payload.data_byte};
                    phase_next  = PH_HEIGHT_HI;
                end
                PH_HEIGHT_HI: begin
                    height_next = hdr_height;
                    col_next    = '0;
                    row_next    = '0;
                    if (width_reg == '0 || hdr_height == '0) begin
                        phase_next = PH_WIDTH_LO;
                    end else begin
                        row_base_next = header_base;
                        phase_next    = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    if (last) begin
                        phase_next = PH_WIDTH_LO;
                        col_next   = '0;
                        row_next   = '0;
                    end else if (row_end) begin
                        col_next      = '0;
                        row_next      = row_inc_full[CFG_W-1:0];
                        row_base_next = row_base_reg + ADDR_BITS'(row_stride);
                    end else begin
                        col_next = col_inc;
                    end
                end
                default: begin
                    phase_next = PH_WIDTH_LO;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WIDTH_LO;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        width_reg    <= width_next;
        height_reg   <= height_next;
        row_base_reg <= row_base_next;
    end

endmodule

>>> rtl/prb_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module prb_queue
    import prb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output cmd_t head_cmd,
    output logic head_valid
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/prb_back.sv
// Back end: colour table writes, table lookup and the output register.
`timescale 1ns / 1ps

module prb_back
    import prb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    input  cmd_t     q_cmd,
    output logic     q_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output out_req_t m_payload
);

    logic                   p1_valid_reg, p1_valid_next;
    logic [DEST_ADDR_W-1:0] p1_addr_reg;
    logic                   p1_last_reg;
    logic                   m_valid_reg, m_valid_next;
    out_req_t               m_payload_reg;
    logic                   out_free;
    logic                   p1_free;
    logic                   rd_en;
    logic                   wr_en;
    logic [COLOR_W-1:0]     table_data;

    assign out_free = !m_valid_reg || m_ready;
    assign p1_free  = !p1_valid_reg || out_free;
    assign q_pop    = q_valid && (q_cmd.is_write || p1_free);
    assign wr_en    = q_pop && q_cmd.is_write;
    assign rd_en    = q_pop && !q_cmd.is_write;

    prb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (q_cmd.index),
        .wr_data (q_cmd.value),
        .rd_en   (rd_en),
        .rd_addr (q_cmd.index),
        .rd_data (table_data)
    );

    assign p1_valid_next = rd_en || (p1_valid_reg && !out_free);
    assign m_valid_next  = out_free ? p1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            p1_addr_reg <= q_cmd.dest_address;
            p1_last_reg <= q_cmd.last_pixel;
        end
        if (out_free && p1_valid_reg) begin
            m_payload_reg.dest_address <= p1_addr_reg;
            m_payload_reg.pixel_value  <= table_data;
            m_payload_reg.last_pixel   <= p1_last_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

>>> rtl/palette_remap_blitter.sv
// Palette remap blitter top level: register port, front end, queue, back end.
//
// Takes one request per clock: a colour table write, or one byte of an 8-bit
// bitmap whose first four bytes are the little-endian width and height. Each
// pixel byte yields a result with its destination word address
// (row base plus column, row base = start_y * row_stride + start_x at header
// time), its colour from the 256-entry table, and a flag on the last pixel.
// A pixel's result passes the queue, the table read and the output register
// before it is valid. s_ready drops for one cycle after every register write
// while the start_y * row_stride product reloads, and otherwise only when the
// two-entry queue is full under output backpressure.
// Table entries must be written before a pixel reads them.
`timescale 1ns / 1ps

module palette_remap_blitter
    import prb_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_req_t               s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_req_t              m_payload
);

    logic [CFG_W-1:0] row_stride_reg;
    logic [CFG_W-1:0] start_x_reg;
    logic [CFG_W-1:0] start_y_reg;
    logic             settle_reg;
    logic             wr_en;
    reg_index_t       reg_sel;

    logic             q_push;
    cmd_t             q_cmd;
    logic             q_ready;
    logic             q_pop;
    cmd_t             q_head;
    logic             q_valid;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_stride_reg <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            settle_reg     <= 1'b0;
        end else begin
            settle_reg <= wr_en;
            if (wr_en) begin
                unique case (reg_sel)
                    REG_ROW_STRIDE: row_stride_reg <= pwdata[CFG_W-1:0];
                    REG_START_X:    start_x_reg    <= pwdata[CFG_W-1:0];
                    REG_START_Y:    start_y_reg    <= pwdata[CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ROW_STRIDE: prdata = APB_DATA_W'(row_stride_reg);
            REG_START_X:    prdata = APB_DATA_W'(start_x_reg);
            REG_START_Y:    prdata = APB_DATA_W'(start_y_reg);
            default:        prdata = '0;
        endcase
    end

    prb_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .row_stride (row_stride_reg),
        .start_x    (start_x_reg),
        .start_y    (start_y_reg),
        .hold       (settle_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .q_push     (q_push),
        .q_cmd      (q_cmd),
        .q_ready    (q_ready)
    );

    prb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_cmd   (q_head),
        .head_valid (q_valid)
    );

    prb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Product reload: no request taken in the cycle after a register write.
    a_settle_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> !s_ready)
        else $error("request accepted while base product reloads");

    // Front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_ready)
        else $error("push into full queue");

    // Queued command kind matches the request that produced it.
    a_cmd_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_cmd.is_write == (s_payload.operation == OP_TABLE_WRITE)))
        else $error("queued command kind mismatch");

    // Back end only pops a queue that holds something.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
